FILE: hdl/software_timer_table_defines.svh
// Assertion macros for the timer table.
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define STT_ASSERT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define STT_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define STT_ASSERT(name, pre, post, msg)
`define STT_ASSERT_NXT(name, pre, post, msg)
`endif
`endif

FILE: hdl/stt_pkg.sv
// Types and codes shared by the timer table.
package stt_pkg;

	localparam logic [1:0] CMD_REGISTER   = 2'd0;
	localparam logic [1:0] CMD_UNREGISTER = 2'd1;
	localparam logic [1:0] CMD_TICK       = 2'd2;

	localparam logic [1:0] KIND_NEW   = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [39:0] now_ms;
		logic [31:0] delay_ms;
		logic        periodic;
		logic [31:0] timer_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] fired_or_new_id;
		logic        last;
	} rsp_t;

	// one slot word; a free slot keeps its free-list link in ident
	typedef struct packed {
		logic [31:0] ident;
		logic [31:0] period;
		logic [40:0] deadline;
		logic        rearm;
	} slot_t;

endpackage

FILE: hdl/software_timer_table.sv
// Timer table top level: slot memory, registration-order list and scan pipeline.
//
// Command channel: an item in request is taken at a clock edge where start is
// high and busy is low. Results leave on result, each valid for exactly one
// cycle while strobe is high; the receiver cannot stall, so nothing waits.
//
// Register: the result strobes in the cycle after busy falls. A full table
// answers with a full result the cycle after accept. Unregister and tick walk
// the list of live timers in registration order through a three-stage
// pipeline (list read, slot read, update and write back), one timer per cycle.
// Fired results come out during the walk, one behind, so the final one can
// carry last; it strobes the cycle after busy falls. Unregister of id 0 and
// the unused code are dropped at accept.
//
// Reset empties the table and sets the next id to 1 at once. Slots never
// used are taken from a fill count; freed slots go on a linked free list
// kept in the slot memory itself, so no clearing pass is needed.
`include "software_timer_table_defines.svh"

module software_timer_table
	import stt_pkg::*;
#(
	parameter int TIMER_SLOTS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic strobe,
	output rsp_t result
);

	localparam int IDXW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNTW = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_REG  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q;
	req_t   item_q;
	logic   tick_q;

	logic [CNTW-1:0] n_q;
	logic [CNTW-1:0] fresh_q;
	logic [IDXW-1:0] head_q;
	logic [31:0]     next_ident_q;

	logic [CNTW-1:0] rd_q;
	logic [CNTW-1:0] w_q;
	logic            v_s1;
	logic            v_s2;
	logic [IDXW-1:0] idx_s2;

	logic        pend_q;
	logic [31:0] pend_id_q;
	logic        strobe_q;
	rsp_t        result_q;

	logic [IDXW-1:0] order_mem [TIMER_SLOTS];
	slot_t           slot_mem  [TIMER_SLOTS];

	logic            om_we;
	logic [IDXW-1:0] om_wa;
	logic [IDXW-1:0] om_wd;
	logic [IDXW-1:0] om_ra;
	logic [IDXW-1:0] om_rd;

	logic            sm_we;
	logic [IDXW-1:0] sm_wa;
	slot_t           sm_wd;
	logic [IDXW-1:0] sm_ra;
	slot_t           sm_rd;

	logic            accept;
	logic            is_full;
	logic [IDXW-1:0] alloc_idx;
	logic            iss;
	logic            scan_done;
	logic            due;
	logic            hit;
	logic            keep;
	logic [40:0]     rearm_dl;
	logic            strobe_d;

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	assign accept    = start && !busy;
	assign is_full   = (n_q == CNTW'(TIMER_SLOTS));
	assign alloc_idx = (fresh_q == n_q) ? fresh_q[IDXW-1:0] : head_q;
	assign iss       = (state_q == ST_SCAN) && (rd_q != n_q);
	assign scan_done = (state_q == ST_SCAN) && !iss && !v_s1 && !v_s2;

	assign due      = (sm_rd.deadline <= {1'b0, item_q.now_ms});
	assign hit      = tick_q ? due : (sm_rd.ident == item_q.timer_id);
	assign keep     = !hit || (tick_q && sm_rd.rearm);
	assign rearm_dl = {1'b0, item_q.now_ms} + {9'd0, sm_rd.period};

	assign strobe_d = (accept && (request.cmd == CMD_REGISTER) && is_full)
		|| (state_q == ST_REG)
		|| ((state_q == ST_SCAN) && v_s2 && tick_q && due && pend_q)
		|| ((state_q == ST_FIN) && pend_q);

	always_comb begin
		om_ra = rd_q[IDXW-1:0];
		if (state_q == ST_REG) begin
			om_we = 1'b1;
			om_wa = n_q[IDXW-1:0];
			om_wd = alloc_idx;
		end else begin
			om_we = v_s2 && keep;
			om_wa = w_q[IDXW-1:0];
			om_wd = idx_s2;
		end
	end

	always_comb begin
		sm_ra = (state_q == ST_SCAN) ? om_rd : head_q;
		sm_wd = sm_rd;
		if (state_q == ST_REG) begin
			sm_we          = 1'b1;
			sm_wa          = alloc_idx;
			sm_wd.ident    = next_ident_q;
			sm_wd.period   = item_q.delay_ms;
			sm_wd.deadline = {1'b0, item_q.now_ms} + {9'd0, item_q.delay_ms};
			sm_wd.rearm    = item_q.periodic;
		end else begin
			sm_we = v_s2 && (!keep || (tick_q && due));
			sm_wa = idx_s2;
			if (!keep) begin
				sm_wd.ident = {{(32 - IDXW){1'b0}}, head_q};
			end else begin
				sm_wd.deadline = rearm_dl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (om_we) begin
			order_mem[om_wa] <= om_wd;
		end
		om_rd <= order_mem[om_ra];
	end

	always_ff @(posedge clk) begin
		if (sm_we) begin
			slot_mem[sm_wa] <= sm_wd;
		end
		sm_rd <= slot_mem[sm_ra];
	end

	always_ff @(posedge clk) begin
		item_q <= accept ? request : item_q;
		idx_s2 <= om_rd;
		case (state_q)
			ST_REG: begin
				result_q <= '{kind: KIND_NEW, fired_or_new_id: next_ident_q, last: 1'b1};
			end
			ST_SCAN: begin
				if (v_s2 && tick_q && due) begin
					pend_id_q <= sm_rd.ident;
					result_q  <= '{kind: KIND_FIRED, fired_or_new_id: pend_id_q, last: 1'b0};
				end
			end
			ST_FIN: begin
				result_q <= '{kind: KIND_FIRED, fired_or_new_id: pend_id_q, last: 1'b1};
			end
			default: begin
				if (accept) begin
					result_q <= '{kind: KIND_FULL, fired_or_new_id: 32'd0, last: 1'b1};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= 1'b0;
			n_q          <= '0;
			fresh_q      <= '0;
			head_q       <= '0;
			next_ident_q <= 32'd1;
			rd_q         <= '0;
			w_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			pend_q       <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= strobe_d;
			v_s1     <= iss;
			v_s2     <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.cmd)
							CMD_REGISTER: begin
								if (!is_full) begin
									state_q <= ST_REG;
								end
							end
							CMD_UNREGISTER: begin
								if (request.timer_id != 32'd0) begin
									tick_q  <= 1'b0;
									rd_q    <= '0;
									w_q     <= '0;
									state_q <= ST_SCAN;
								end
							end
							CMD_TICK: begin
								tick_q  <= 1'b1;
								rd_q    <= '0;
								w_q     <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_REG: begin
					n_q <= n_q + 1'b1;
					if (fresh_q == n_q) begin
						fresh_q <= fresh_q + 1'b1;
					end else begin
						head_q <= sm_rd.ident[IDXW-1:0];
					end
					next_ident_q <= (next_ident_q == 32'hFFFF_FFFF) ? 32'd1
						: next_ident_q + 32'd1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (iss) begin
						rd_q <= rd_q + 1'b1;
					end
					if (v_s2) begin
						if (keep) begin
							w_q <= w_q + 1'b1;
						end else begin
							head_q <= idx_s2;
						end
						if (tick_q && due) begin
							pend_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					n_q     <= w_q;
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`STT_ASSERT(a_free_count, 1'b1, (fresh_q >= n_q) && (fresh_q <= CNTW'(TIMER_SLOTS)), "fill count below live count")
	`STT_ASSERT(a_compact, state_q == ST_SCAN, w_q <= rd_q, "list write passed list read")
	`STT_ASSERT_NXT(a_reg_result, state_q == ST_REG, strobe && (result.kind == KIND_NEW) && result.last, "register gave no id")
	`STT_ASSERT(a_full_only, strobe && (result.kind == KIND_FULL), $past(n_q) == CNTW'(TIMER_SLOTS), "full reported with free slots")
	`STT_ASSERT_NXT(a_fin_flush, state_q == ST_FIN, !pend_q && !busy, "pending fire kept past scan end")

endmodule
